@@ src/assert_macros.svh @@
// Assertion macros for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define PTS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

@@ src/pts_pkg.sv @@
// Shared types and constants for the priority task scheduler.
`timescale 1ns / 1ps

package pts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int TASK_ID_W = 4;
    localparam int PRIO_W    = 8;
    localparam int DELAY_W   = 32;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
    localparam logic [OP_W-1:0] OP_DELAY  = 2'd2;
    localparam logic [OP_W-1:0] OP_START  = 2'd3;

    typedef struct packed {
        logic                 susp;
        logic [DELAY_W-1:0]   delay;
        logic [PRIO_W-1:0]    prio;
        logic [SLOT_W-1:0]    nxt;
    } pts_entry_t;

    typedef struct packed {
        logic                 re;
        logic [SLOT_W-1:0]    raddr;
        logic                 we;
        logic [SLOT_W-1:0]    waddr;
        pts_entry_t           wdata;
    } pts_ram_req_t;

    typedef struct packed {
        logic                 ok;
        logic                 switch_needed;
        logic                 is_idle;
        logic [TASK_ID_W-1:0] task_id;
    } pts_result_t;

endpackage

@@ src/pts_slot_ram.sv @@
// Task slot table: one-write, one-read synchronous memory with write-to-read forwarding.
`timescale 1ns / 1ps

module pts_slot_ram
    import pts_pkg::*;
(
    input  logic         aclk,
    input  pts_ram_req_t req,
    output pts_entry_t   rdata
);

    pts_entry_t mem [MAX_TASKS];
    pts_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            // forward a same-cycle write to the same slot
            if (req.we && req.waddr == req.raddr) begin
                rdata_reg <= req.wdata;
            end else begin
                rdata_reg <= mem[req.raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/pts_ctrl.sv @@
// Scheduler sequencer: command decode, ring walk and slot table updates.
`timescale 1ns / 1ps

module pts_ctrl
    import pts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    in_opcode,
    input  logic [PRIO_W-1:0]  in_prio,
    input  logic [DELAY_W-1:0] in_ticks,
    output logic               res_valid,
    input  logic               res_ready,
    output pts_result_t        res,
    output pts_ram_req_t       ram_req,
    input  pts_entry_t         ram_rdata
);

`include "assert_macros.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CR_RD = 3'd1;
    localparam logic [2:0] ST_CR_WR = 3'd2;
    localparam logic [2:0] ST_DL_RD = 3'd3;
    localparam logic [2:0] ST_TICK  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic               idle_reg, idle_next;
    logic [PRIO_W-1:0]  prio_reg, prio_next;
    logic [DELAY_W-1:0] ticks_reg, ticks_next;
    logic [SLOT_W-1:0]  walk_reg, walk_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [PRIO_W-1:0]  best_reg, best_next;
    logic [SLOT_W-1:0]  pick_reg, pick_next;
    logic [SLOT_W-1:0]  nhead_reg, nhead_next;
    pts_entry_t         ent_reg, ent_next;
    logic [SLOT_W-1:0]  rid_reg, rid_next;
    logic               rcreate_reg, rcreate_next;
    logic               rsw_reg, rsw_next;
    logic               rok_reg, rok_next;

    // per-slot tick update
    logic               tk_susp;
    logic [DELAY_W-1:0] tk_delay;
    logic [PRIO_W-1:0]  tk_best;
    logic [SLOT_W-1:0]  tk_pick;
    logic [SLOT_W-1:0]  tk_nhead;
    logic               tk_last;
    logic               tk_idle;

    logic               accept;
    logic [SLOT_W-1:0]  new_slot;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign new_slot = count_reg[SLOT_W-1:0];

    always_comb begin
        tk_susp  = ram_rdata.susp;
        tk_delay = ram_rdata.delay;
        if (ram_rdata.susp && ram_rdata.delay != '0) begin
            tk_delay = ram_rdata.delay - DELAY_W'(1);
            if (tk_delay == '0) begin
                tk_susp = 1'b0;
            end
        end
        tk_best = best_reg;
        tk_pick = pick_reg;
        if (!tk_susp && ram_rdata.prio > best_reg) begin
            tk_best = ram_rdata.prio;
            tk_pick = walk_reg;
        end
        tk_nhead = (n_reg == '0) ? ram_rdata.nxt : nhead_reg;
        tk_last  = !((n_reg + CNT_W'(1)) < count_reg);
        tk_idle  = (tk_best == '0);
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        idle_next    = idle_reg;
        prio_next    = prio_reg;
        ticks_next   = ticks_reg;
        walk_next    = walk_reg;
        n_next       = n_reg;
        best_next    = best_reg;
        pick_next    = pick_reg;
        nhead_next   = nhead_reg;
        ent_next     = ent_reg;
        rid_next     = rid_reg;
        rcreate_next = rcreate_reg;
        rsw_next     = rsw_reg;
        rok_next     = rok_reg;
        ram_req      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    prio_next    = in_prio;
                    ticks_next   = in_ticks;
                    rcreate_next = 1'b0;
                    rsw_next     = 1'b0;
                    rok_next     = 1'b1;
                    rid_next     = '0;
                    state_next   = ST_DONE;
                    unique case (in_opcode)
                        OP_CREATE: begin
                            rcreate_next = 1'b1;
                            if (count_reg >= CNT_W'(MAX_TASKS)) begin
                                rok_next = 1'b0;
                            end else if (count_reg == '0) begin
                                // first task links to itself
                                ram_req.we          = 1'b1;
                                ram_req.waddr       = new_slot;
                                ram_req.wdata.susp  = 1'b0;
                                ram_req.wdata.delay = '0;
                                ram_req.wdata.prio  = in_prio;
                                ram_req.wdata.nxt   = new_slot;
                                head_next           = new_slot;
                                count_next          = count_reg + CNT_W'(1);
                                rid_next            = new_slot;
                            end else begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = head_reg;
                                state_next    = ST_CR_RD;
                            end
                        end
                        OP_DELAY: begin
                            if (idle_reg) begin
                                rok_next = 1'b0;
                            end else begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = cur_reg;
                                state_next    = ST_DL_RD;
                            end
                        end
                        OP_START: begin
                            if (count_reg != '0) begin
                                cur_next  = head_reg;
                                idle_next = 1'b0;
                            end
                        end
                        OP_TICK: begin
                            if (count_reg == '0) begin
                                idle_next = 1'b1;
                                rsw_next  = !idle_reg;
                            end else begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = head_reg;
                                walk_next     = head_reg;
                                n_next        = '0;
                                best_next     = '0;
                                pick_next     = '0;
                                state_next    = ST_TICK;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CR_RD: begin
                // new slot takes the head's successor
                ram_req.we          = 1'b1;
                ram_req.waddr       = new_slot;
                ram_req.wdata.susp  = 1'b0;
                ram_req.wdata.delay = '0;
                ram_req.wdata.prio  = prio_reg;
                ram_req.wdata.nxt   = ram_rdata.nxt;
                ent_next            = ram_rdata;
                state_next          = ST_CR_WR;
            end
            ST_CR_WR: begin
                ram_req.we        = 1'b1;
                ram_req.waddr     = head_reg;
                ram_req.wdata     = ent_reg;
                ram_req.wdata.nxt = new_slot;
                rid_next          = new_slot;
                count_next        = count_reg + CNT_W'(1);
                state_next        = ST_DONE;
            end
            ST_DL_RD: begin
                ram_req.we          = 1'b1;
                ram_req.waddr       = cur_reg;
                ram_req.wdata.susp  = 1'b1;
                ram_req.wdata.delay = ticks_reg;
                ram_req.wdata.prio  = ram_rdata.prio;
                ram_req.wdata.nxt   = ram_rdata.nxt;
                state_next          = ST_DONE;
            end
            ST_TICK: begin
                ram_req.we          = 1'b1;
                ram_req.waddr       = walk_reg;
                ram_req.wdata.susp  = tk_susp;
                ram_req.wdata.delay = tk_delay;
                ram_req.wdata.prio  = ram_rdata.prio;
                ram_req.wdata.nxt   = ram_rdata.nxt;
                best_next           = tk_best;
                pick_next           = tk_pick;
                nhead_next          = tk_nhead;
                if (tk_last) begin
                    if (!tk_idle) begin
                        head_next = tk_nhead;
                        cur_next  = tk_pick;
                    end
                    idle_next  = tk_idle;
                    rsw_next   = (idle_reg != tk_idle) || (!tk_idle && cur_reg != tk_pick);
                    state_next = ST_DONE;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ram_rdata.nxt;
                    walk_next     = ram_rdata.nxt;
                    n_next        = n_reg + CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            cur_reg   <= '0;
            idle_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            idle_reg  <= idle_next;
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg    <= prio_next;
        ticks_reg   <= ticks_next;
        walk_reg    <= walk_next;
        n_reg       <= n_next;
        best_reg    <= best_next;
        pick_reg    <= pick_next;
        nhead_reg   <= nhead_next;
        ent_reg     <= ent_next;
        rid_reg     <= rid_next;
        rcreate_reg <= rcreate_next;
        rsw_reg     <= rsw_next;
        rok_reg     <= rok_next;
    end

    assign res_valid         = (state_reg == ST_DONE);
    assign res.ok            = rok_reg;
    assign res.switch_needed = rsw_reg;
    assign res.is_idle       = idle_reg;
    assign res.task_id       = rcreate_reg ? TASK_ID_W'(rid_reg)
                             : (idle_reg ? '0 : TASK_ID_W'(cur_reg));

    `PTS_ASSERT(a_count_max, count_reg <= CNT_W'(MAX_TASKS), "task count above table size")
    `PTS_NEVER(a_run_empty, !idle_reg && count_reg == '0, "task running with empty table")
    `PTS_NEVER(a_walk_range, state_reg == ST_TICK && n_reg >= count_reg, "ring walk overran")
    `PTS_ASSERT(a_done_release, res_valid && res_ready |=> state_reg == ST_IDLE, "result not released")

endmodule

@@ src/priority_task_scheduler_top.sv @@
// Top level of the priority round-robin task scheduler.
`timescale 1ns / 1ps
// Usage:
//   Commands enter on the s_ channel: s_tuser carries the opcode (tick, create,
//   delay, start), s_tdata the task priority and the delay count. Every command
//   yields exactly one result transfer on the m_ channel carrying the task id,
//   the idle flag, the switch flag and the ok flag.
//   Flow: a command is taken only while the sequencer is idle. A tick walks
//   the task ring one slot per cycle through the slot table's single read
//   port, visiting each of the task_count slots of the ring once.
//   Reset: aresetn low at a rising aclk edge empties the table, makes the idle task
//   current and drops any pending result. The slot table itself needs no
//   clearing pass: a slot is always written at create before it is read.
//   Stall: results wait in an output register; while m_tready is low the
//   sequencer may still finish the next command and then holds it until the
//   output register frees, with s_tready low meanwhile.

module priority_task_scheduler_top
    import pts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] task_priority, [39:8] delay_ticks
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [3:0] task_id, [4] is_idle, [5] switch_needed, [6] ok, [7] zero
);

    pts_ram_req_t ram_req;
    pts_entry_t   ram_rdata;
    pts_result_t  res;
    logic         res_valid;
    logic         res_ready;

    logic         out_valid_reg, out_valid_next;
    pts_result_t  out_data_reg, out_data_next;

    pts_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser),
        .in_prio   (s_tdata[7:0]),
        .in_ticks  (s_tdata[39:8]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    pts_slot_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // output register: load a finished result when empty or draining
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule
